@@ rtl/cce_pkg.sv @@
// Package for the character canvas edit engine: command codes, the queued
// command struct and shared constants. No dependencies.
package cce_pkg;

  typedef enum logic [2:0] {
    REQ_BEGIN   = 3'd0,
    REQ_KEY     = 3'd1,
    REQ_MOVE    = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_UNDO    = 3'd4,
    REQ_CLEAR   = 3'd5,
    REQ_WRITE   = 3'd6,
    REQ_READ    = 3'd7
  } req_t;

  localparam logic [7:0] BLANK       = 8'h20;
  localparam logic [7:0] ARROW_UP    = 8'd72;
  localparam logic [7:0] ARROW_LEFT  = 8'd75;
  localparam logic [7:0] ARROW_RIGHT = 8'd77;
  localparam logic [7:0] ARROW_DOWN  = 8'd80;
  localparam logic [7:0] PRINT_LOW   = 8'd31;
  localparam logic [7:0] PRINT_HIGH  = 8'd127;

  // One classified command as it travels from front to back.
  typedef struct packed {
    req_t        req;
    logic [7:0]  key_code;
    logic        key_special;
    logic [7:0]  row_shift;
    logic [7:0]  col_shift;
    logic [7:0]  old_char;
    logic [7:0]  new_char;
    logic [4:0]  cell_row;
    logic [6:0]  cell_col;
    logic [7:0]  cell_data;
    logic        addr_ok;
  } cmd_t;

endpackage

@@ rtl/cce_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/cce_front.sv @@
// Front end: accepts input items, checks cell addresses and pushes
// commands into a two-entry queue. Depends on cce_pkg.
module cce_front
  import cce_pkg::*;
#(
  parameter int ROWS = 22,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_key_code,
  input  logic       in_key_special,
  input  logic [7:0] in_row_shift,
  input  logic [7:0] in_col_shift,
  input  logic [7:0] in_old_char,
  input  logic [7:0] in_new_char,
  input  logic [4:0] in_cell_row,
  input  logic [6:0] in_cell_col,
  input  logic [7:0] in_cell_data,
  output logic       q_valid,
  input  logic       q_pop,
  output cmd_t       q_cmd
);
  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push;
  cmd_t       c;

  always_comb begin
    c.req         = req_t'(in_req_type);
    c.key_code    = in_key_code;
    c.key_special = in_key_special;
    c.row_shift   = in_row_shift;
    c.col_shift   = in_col_shift;
    c.old_char    = in_old_char;
    c.new_char    = in_new_char;
    c.cell_row    = in_cell_row;
    c.cell_col    = in_cell_col;
    c.cell_data   = in_cell_data;
    c.addr_ok     = ({27'd0, in_cell_row} < ROWS) && ({25'd0, in_cell_col} < COLS);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r] <= c;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("ready while full");
endmodule

@@ rtl/cce_back.sv @@
// Back end: carries out commands on the canvas and backup RAMs with a
// cell-walking sequencer and a registered result. Depends on cce_pkg, cce_ram.
module cce_back
  import cce_pkg::*;
#(
  parameter int ROWS = 22,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_char,
  output logic [4:0] out_cursor_row,
  output logic [6:0] out_cursor_col
);
  localparam int CELLS = ROWS * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  typedef enum logic [7:0] {
    S_INIT  = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_COPY  = 8'b00000100,
    S_WALK  = 8'b00001000,
    S_CELL  = 8'b00010000,
    S_CELL2 = 8'b00100000,
    S_DRAIN = 8'b01000000,
    S_OUT   = 8'b10000000
  } st_t;

  st_t st_r, st_nxt;
  cmd_t cmd_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [6:0] erow_r, erow_nxt;
  logic [7:0] ecol_r, ecol_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic ov_r, ov_nxt;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] idx_r, idx_nxt;
  // Walk info delayed by one register to line up with registered RAM reads.
  logic p_v_r, p_blank_r;
  logic [AW-1:0] p_addr_r;
  logic c_we, b_we;
  logic [AW-1:0] c_wa, b_wa, c_ra, b_ra;
  logic [7:0] c_wd, b_wd, c_rd, b_rd;
  logic rd_v, rd_blank;
  logic signed [9:0] sr, sc;
  logic last;

  cce_ram #(.WIDTH(8), .DEPTH(CELLS)) u_canvas (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  cce_ram #(.WIDTH(8), .DEPTH(CELLS)) u_backup (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

  assign last = (row_r == RW'(ROWS - 1)) && (col_r == CW'(COLS - 1));
  assign cell_addr = AW'(cmd_r.cell_row * COLS) + AW'(cmd_r.cell_col);
  assign sr = $signed({{(10-RW){1'b0}}, row_r})
            - $signed({{2{cmd_r.row_shift[7]}}, cmd_r.row_shift});
  assign sc = $signed({{(10-CW){1'b0}}, col_r})
            - $signed({{2{cmd_r.col_shift[7]}}, cmd_r.col_shift});

  assign out_valid      = ov_r;
  assign out_read_char  = rd_r;
  assign out_cursor_row = erow_r[4:0];
  assign out_cursor_col = ecol_r[6:0];
  assign q_pop = (st_r == S_IDLE) && q_valid && !ov_r;

  always_comb begin
    st_nxt = st_r; row_nxt = row_r; col_nxt = col_r; idx_nxt = idx_r;
    erow_nxt = erow_r; ecol_nxt = ecol_r; rd_nxt = rd_r; ov_nxt = ov_r;
    c_we = 1'b0; c_wa = p_addr_r; c_wd = BLANK;
    b_we = 1'b0; b_wa = p_addr_r; b_wd = c_rd;
    c_ra = idx_r; b_ra = idx_r;
    rd_v = 1'b0; rd_blank = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_INIT: begin
        // Clearing pass: both RAMs to spaces.
        c_we = 1'b1; b_we = 1'b1; c_wa = idx_r; b_wa = idx_r; b_wd = BLANK;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(CELLS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        row_nxt = '0; col_nxt = '0; idx_nxt = '0;
        if (q_pop) begin
          unique case (q_cmd.req)
            REQ_KEY, REQ_WRITE, REQ_READ: st_nxt = S_CELL;
            default: st_nxt = (q_cmd.req == REQ_UNDO) ? S_WALK : S_COPY;
          endcase
        end
      end
      S_COPY: begin
        // Read canvas; the backup write follows in the next cycle.
        rd_v = 1'b1;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(CELLS - 1)) st_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (cmd_r.req == REQ_BEGIN) begin
          erow_nxt = '0; ecol_nxt = '0; rd_nxt = 8'd0; st_nxt = S_OUT;
        end else begin
          st_nxt = S_WALK; idx_nxt = '0;
        end
      end
      S_WALK: begin
        // Rebuild canvas from backup (move, undo), from itself (replace) or with spaces (clear); row/col track idx.
        rd_v = 1'b1;
        if (cmd_r.req == REQ_MOVE) begin
          rd_blank = (sr < 0) || (sr >= ROWS) || (sc < 0) || (sc >= COLS);
          b_ra = AW'(sr[RW:0] * COLS) + AW'(sc[CW:0]);
        end
        idx_nxt = idx_r + AW'(1);
        if (col_r == CW'(COLS - 1)) begin
          col_nxt = '0; row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
        if (last) st_nxt = S_CELL2;
      end
      S_CELL: begin
        c_ra = (cmd_r.req == REQ_READ) ? cell_addr : '0;
        unique case (cmd_r.req)
          REQ_KEY: begin
            if (cmd_r.key_special) begin
              // Arrow codes step the cursor, clamped at the canvas edges.
              if (cmd_r.key_code == ARROW_LEFT) begin
                if (ecol_r != '0) ecol_nxt = ecol_r - 8'd1;
              end else if (cmd_r.key_code == ARROW_UP) begin
                if (erow_r != '0) erow_nxt = erow_r - 7'd1;
              end else if (cmd_r.key_code == ARROW_RIGHT) begin
                if (ecol_r + 8'd1 < COLS) ecol_nxt = ecol_r + 8'd1;
              end else if (cmd_r.key_code == ARROW_DOWN) begin
                if (erow_r + 7'd1 < ROWS) erow_nxt = erow_r + 7'd1;
              end
            end else if (cmd_r.key_code > PRINT_LOW && cmd_r.key_code < PRINT_HIGH) begin
              c_we = 1'b1;
              c_wa = AW'(erow_r * COLS) + AW'(ecol_r);
              c_wd = cmd_r.key_code;
            end
          end
          REQ_WRITE: begin
            c_we = cmd_r.addr_ok; c_wa = cell_addr; c_wd = cmd_r.cell_data;
          end
          default: begin
          end
        endcase
        st_nxt = S_CELL2;
      end
      S_CELL2: begin
        rd_nxt = (cmd_r.req == REQ_READ && cmd_r.addr_ok) ? c_rd : 8'd0;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // Write stage of the copy / walk pipelines.
    if (p_v_r) begin
      if (st_r == S_COPY || st_r == S_DRAIN) begin
        b_we = 1'b1; b_wd = c_rd;
      end else begin
        c_we = 1'b1;
        priority if (p_blank_r || cmd_r.req == REQ_CLEAR) c_wd = BLANK;
        else if (cmd_r.req == REQ_REPLACE && c_rd == cmd_r.old_char)
          c_wd = cmd_r.new_char;
        else if (cmd_r.req == REQ_REPLACE) c_wd = c_rd;
        else c_wd = b_rd;
      end
    end
    if (st_r == S_WALK && cmd_r.req == REQ_REPLACE) c_ra = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; idx_r <= '0; ov_r <= 1'b0; p_v_r <= 1'b0;
      erow_r <= '0; ecol_r <= '0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; ov_r <= ov_nxt;
      p_v_r <= rd_v; erow_r <= erow_nxt; ecol_r <= ecol_nxt;
    end
    row_r <= row_nxt; col_r <= col_nxt; rd_r <= rd_nxt;
    p_addr_r <= idx_r; p_blank_r <= rd_blank;
    if (q_pop) cmd_r <= q_cmd;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("pop while busy");
  a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r) else $error("result dropped");
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    erow_r < ROWS && ecol_r < COLS) else $error("cursor out of range");
endmodule

@@ rtl/char_canvas_edit_engine_top.sv @@
// Work per item with an idle back end: key, write_cell and read_cell take one cell
// access; begin_edit a backup copy pass; undo a rebuild pass from the backup; move,
// replace and clear a backup copy pass, then a rebuild pass, one cell a cycle.
// Throughput: one item at a time; the back starts the next queued item only after
// the held result is accepted, while a two-entry queue lets the front take items.
// Reset: synchronous active low, then a pass fills both RAMs with spaces.
module char_canvas_edit_engine_top
  import cce_pkg::*;
#(
  parameter int ROWS = 22,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_key_code,
  input  logic       in_key_special,
  input  logic [7:0] in_row_shift,
  input  logic [7:0] in_col_shift,
  input  logic [7:0] in_old_char,
  input  logic [7:0] in_new_char,
  input  logic [4:0] in_cell_row,
  input  logic [6:0] in_cell_col,
  input  logic [7:0] in_cell_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_char,
  output logic [4:0] out_cursor_row,
  output logic [6:0] out_cursor_col
);
  // The front queues each item; the back runs it and holds one result.
  logic q_valid, q_pop;
  cmd_t q_cmd;

  cce_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_key_code,
    .in_key_special, .in_row_shift, .in_col_shift, .in_old_char, .in_new_char,
    .in_cell_row, .in_cell_col, .in_cell_data, .q_valid, .q_pop, .q_cmd);

  cce_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_ready,
    .out_read_char, .out_cursor_row, .out_cursor_col);
endmodule
